// File: rtl/b64sc_pkg.sv
// Shared types, constants and character mapping functions for the Base64 stream codec.
package b64sc_pkg;

  localparam int unsigned MaxResults = 4;
  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [7:0] PlusChar = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } dir_e;

  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  group_position;
    logic [1:0]  pad_seen;
    logic        discard_to_end;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [2:0]            count;
  } batch_t;

  // sextet to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26) begin
      enc_char = 8'h41 + w;
    end else if (s < 6'd52) begin
      enc_char = w + 8'd71;
    end else if (s < 6'd62) begin
      enc_char = w - 8'd4;
    end else if (s == 6'd62) begin
      enc_char = PlusChar;
    end else begin
      enc_char = SlashChar;
    end
  endfunction

  // alphabet character to sextet; bit 6 set flags a character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c + 8'd4;
    end else if (c == PlusChar) begin
      v = 8'd62;
    end else if (c == SlashChar) begin
      v = 8'd63;
    end else begin
      v = 8'h40;
    end
    sextet_of = v[6:0];
  endfunction

endpackage

// File: rtl/b64sc_step.sv
// Per-item encode/decode step: next message state and the batch of results.
module b64sc_step import b64sc_pkg::*; (
  input  dir_e       direction_i,
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     state_o,
  output batch_t     batch_o
);

  logic [1:0]  pos;
  logic [23:0] enc_g;
  logic        is_pad;
  logic [6:0]  sx_raw;
  logic [5:0]  sx;
  logic        dec_err;
  logic [1:0]  pad_n;
  logic [23:0] sx_w;
  logic [23:0] dec_g;
  logic [2:0]  cnt;

  always_comb begin
    pos     = state_i.group_position;
    state_o = state_i;
    batch_o = '0;
    enc_g   = state_i.group_bits;
    is_pad  = (byte_i == PadChar);
    sx_raw  = sextet_of(byte_i);
    sx      = is_pad ? 6'd0 : sx_raw[5:0];
    pad_n   = state_i.pad_seen + {1'b0, is_pad};
    sx_w    = {18'd0, sx};
    dec_g   = state_i.group_bits;
    cnt     = 3'd3;

    if (is_pad) begin
      dec_err = (pos < 2'd2) || (pos == 2'd2 && last_i) || (pos == 2'd3 && !last_i);
    end else begin
      dec_err = sx_raw[6] || (state_i.pad_seen != 2'd0) || (pos != 2'd3 && last_i);
    end

    unique case (direction_i)
      DirEncode: begin
        case (pos)
          2'd0: begin
            enc_g = {byte_i, 16'd0};
            batch_o.res[0].out_byte = enc_char(enc_g[23:18]);
            batch_o.count = 3'd1;
            if (last_i) begin
              batch_o.res[1].out_byte = enc_char(enc_g[17:12]);
              batch_o.res[2].out_byte = PadChar;
              batch_o.res[3].out_byte = PadChar;
              batch_o.res[3].out_last = 1'b1;
              batch_o.count = 3'd4;
            end
            state_o.group_position = 2'd1;
          end
          2'd1: begin
            enc_g[15:8] = byte_i;
            batch_o.res[0].out_byte = enc_char(enc_g[17:12]);
            batch_o.count = 3'd1;
            if (last_i) begin
              batch_o.res[1].out_byte = enc_char(enc_g[11:6]);
              batch_o.res[2].out_byte = PadChar;
              batch_o.res[2].out_last = 1'b1;
              batch_o.count = 3'd3;
            end
            state_o.group_position = 2'd2;
          end
          default: begin
            enc_g[7:0] = byte_i;
            batch_o.res[0].out_byte = enc_char(enc_g[11:6]);
            batch_o.res[1].out_byte = enc_char(enc_g[5:0]);
            batch_o.res[1].out_last = last_i;
            batch_o.count = 3'd2;
            state_o.group_position = 2'd0;
          end
        endcase
        state_o.group_bits = enc_g;
        if (last_i) begin
          state_o = '0;
        end
      end
      DirDecode: begin
        if (state_i.discard_to_end) begin
          if (last_i) begin
            state_o = '0;
          end
        end else if (dec_err) begin
          state_o = '0;
          state_o.discard_to_end = !last_i;
          batch_o.res[0].out_last  = 1'b1;
          batch_o.res[0].out_error = 1'b1;
          batch_o.count = 3'd1;
        end else begin
          case (pos)
            2'd0:    dec_g = state_i.group_bits | (sx_w << 18);
            2'd1:    dec_g = state_i.group_bits | (sx_w << 12);
            2'd2:    dec_g = state_i.group_bits | (sx_w << 6);
            default: dec_g = state_i.group_bits | sx_w;
          endcase
          if (pos != 2'd3) begin
            state_o.group_bits     = dec_g;
            state_o.group_position = pos + 2'd1;
            state_o.pad_seen       = pad_n;
          end else begin
            case (pad_n)
              2'd0:    cnt = 3'd3;
              2'd1:    cnt = 3'd2;
              default: cnt = 3'd1;
            endcase
            batch_o.res[0].out_byte = dec_g[23:16];
            batch_o.res[1].out_byte = dec_g[15:8];
            batch_o.res[2].out_byte = dec_g[7:0];
            batch_o.res[0].out_last = last_i && (cnt == 3'd1);
            batch_o.res[1].out_last = last_i && (cnt == 3'd2);
            batch_o.res[2].out_last = last_i && (cnt == 3'd3);
            batch_o.count = cnt;
            state_o = '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/b64sc_obuf.sv
// Result register: holds one item's batch of results and hands them out one per cycle while the receiver is ready.
module b64sc_obuf import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  batch_t     batch_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  res_t [MaxResults-1:0] entries_q;
  logic [2:0]            cnt_q;
  logic [1:0]            idx_q;
  logic                  fire;
  res_t                  head;

  assign out_valid_o = (cnt_q != 3'd0);
  assign fire        = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready_i);
  assign head        = entries_q[idx_q];
  assign out_byte_o  = head.out_byte;
  assign out_last_o  = head.out_last;
  assign out_error_o = head.out_error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      idx_q <= 2'd0;
    end else if (fire) begin
      cnt_q <= cnt_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entries_q <= batch_i.res;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result count out of range");

  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready_i)))
    else $error("batch loaded over pending results");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_error_o) |-> (out_last_o && out_byte_o == 8'd0))
    else $error("error result malformed");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !load_i && cnt_q > 3'd1) |=> (idx_q == $past(idx_q) + 2'd1))
    else $error("result index did not advance");

endmodule

// File: rtl/base64_stream_codec.sv
// Top level of the Base64 stream codec: input register, message state, result register.
// Each request goes from the input register, as a batch, into the result register.
// One request per cycle while each gives at most one result and the receiver is ready; a
// request with more holds the single result register until all are taken (encode averages
// four characters per three bytes). Reset clears message state and selects encode.
module base64_stream_codec import b64sc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_direction_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  dir_e       direction_q;
  state_t     state_q;
  state_t     state_d;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       can_load;
  logic       load;
  logic       cfg_fire;
  batch_t     batch;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign load        = in_valid_q && can_load;
  assign in_ready_o  = !in_valid_q || load;

  b64sc_step u_step (
    .direction_i (direction_q),
    .state_i     (state_q),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .state_o     (state_d),
    .batch_o     (batch)
  );

  b64sc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .batch_i     (batch),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .out_error_o (out_error_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DirEncode;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        direction_q <= dir_e'(cfg_direction_i);
        state_q     <= '0;
      end else if (load) begin
        state_q <= state_d;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

endmodule

// File: bench/tb_base64_stream_codec.sv
// Self-checking testbench for base64_stream_codec against a request-level predictor.
module tb_base64_stream_codec import b64sc_pkg::*; ();

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sym_req_t;

  typedef enum logic [2:0] {
    MangleByte,
    MangleStrayPad,
    MangleShort,
    MangleLong,
    MangleNone
  } mangle_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_direction_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       out_error_o;

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  sym_req_t pending_reqs[$];
  res_t     expected_syms[$];

  // predictor copy of the codec state
  dir_e        pred_dir = DirEncode;
  logic [23:0] pred_bits = '0;
  logic [1:0]  pred_pos = '0;
  logic [1:0]  pred_pads = '0;
  logic        pred_drop = 1'b0;

  int       err_count = 0;
  int       queued_reqs = 0;
  int       in_gap = 0;
  int       out_wait = 0;
  int       rx_hold = 0;
  bit       no_idle = 1'b0;
  sym_req_t next_req;
  res_t     got;
  res_t     want;

  base64_stream_codec dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_direction_i (cfg_direction_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o),
    .out_error_o     (out_error_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    return b64_alphabet[s];
  endfunction

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] v;
    int         k;
    v = 7'h40;
    for (k = 0; k < 64; k++) begin
      if (b64_alphabet[k] == c) v = k[6:0];
    end
    return v;
  endfunction

  task automatic note_result(input logic [7:0] b, input logic l, input logic e);
    res_t r;
    r = {b, l, e};
    expected_syms = {expected_syms, r};
  endtask

  task automatic clear_msg();
    pred_bits = '0;
    pred_pos  = '0;
    pred_pads = '0;
    pred_drop = 1'b0;
  endtask

  task automatic base64_predict(input logic [7:0] c, input logic last);
    logic [23:0] g;
    logic [6:0]  v;
    logic [5:0]  s;
    logic        bad;
    int          cnt;
    int          k;
    if (pred_dir == DirEncode) begin
      case (pred_pos)
        2'd0: begin
          g = {c, 16'h0000};
          note_result(b64_char(g[23:18]), 1'b0, 1'b0);
          if (last) begin
            note_result(b64_char(g[17:12]), 1'b0, 1'b0);
            note_result(PadChar, 1'b0, 1'b0);
            note_result(PadChar, 1'b1, 1'b0);
          end
          pred_pos = 2'd1;
        end
        2'd1: begin
          g = pred_bits | {8'h00, c, 8'h00};
          note_result(b64_char(g[17:12]), 1'b0, 1'b0);
          if (last) begin
            note_result(b64_char(g[11:6]), 1'b0, 1'b0);
            note_result(PadChar, 1'b1, 1'b0);
          end
          pred_pos = 2'd2;
        end
        default: begin
          g = pred_bits | {16'h0000, c};
          note_result(b64_char(g[11:6]), 1'b0, 1'b0);
          note_result(b64_char(g[5:0]), last, 1'b0);
          pred_pos = 2'd0;
        end
      endcase
      pred_bits = g;
      if (last) clear_msg();
    end else if (pred_drop) begin
      if (last) clear_msg();
    end else begin
      bad = 1'b0;
      s   = '0;
      if (c == PadChar) begin
        if (pred_pos < 2'd2 || (pred_pos == 2'd2 && last) || (pred_pos == 2'd3 && !last)) begin
          bad = 1'b1;
        end else begin
          pred_pads = pred_pads + 2'd1;
        end
      end else begin
        v = b64_value(c);
        s = v[5:0];
        if (v[6] || pred_pads != 2'd0 || (pred_pos < 2'd3 && last)) bad = 1'b1;
      end
      if (bad) begin
        clear_msg();
        pred_drop = !last;
        note_result(8'h00, 1'b1, 1'b1);
      end else begin
        pred_bits = pred_bits | ({18'h0, s} << (18 - 6 * pred_pos));
        if (pred_pos != 2'd3) begin
          pred_pos = pred_pos + 2'd1;
        end else begin
          cnt = (pred_pads > 2'd2) ? 1 : 3 - pred_pads;
          for (k = 0; k < cnt; k++) begin
            note_result(pred_bits[23 - 8 * k -: 8], last && (k == cnt - 1), 1'b0);
          end
          clear_msg();
        end
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
      in_last_i  <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        base64_predict(in_byte_i, in_last_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= next_req.data;
          in_last_i  <= next_req.last;
          in_gap = no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {out_byte_o, out_last_o, out_error_o};
        if (expected_syms.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %h last %b error %b",
                   $time, got.out_byte, got.out_last, got.out_error);
          err_count++;
        end else begin
          want = expected_syms.pop_front();
          if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
              got.out_error !== want.out_error) begin
            $display({"%0t: mismatch, expected byte %h last %b error %b, ",
                      "actual byte %h last %b error %b"},
                     $time, want.out_byte, want.out_last, want.out_error,
                     got.out_byte, got.out_last, got.out_error);
            err_count++;
          end
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_ready_i <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait = out_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [7:0] data, input logic last);
    sym_req_t r;
    r = {data, last};
    pending_reqs = {pending_reqs, r};
    queued_reqs++;
  endtask

  task automatic add_text(input string s, input bit close);
    int k;
    for (k = 0; k < s.len(); k++) queue_req(s[k], close && (k == s.len() - 1));
  endtask

  task automatic add_random_bytes(input int n, input bit close);
    logic [7:0] b;
    int         k;
    for (k = 0; k < n; k++) begin
      b = 8'($urandom);
      queue_req(b, close && (k == n - 1));
    end
  endtask

  // well-formed text for nbytes random bytes, sometimes mangled
  task automatic add_decode_msg(input int nbytes, input bit close);
    logic [7:0]  txt[$];
    logic [23:0] g;
    mangle_e     mangle;
    int          i;
    int          n;
    int          k;
    i = 0;
    while (i < nbytes) begin
      n = (nbytes - i > 3) ? 3 : nbytes - i;
      g = 24'($urandom);
      txt = {txt, b64_char(g[23:18])};
      txt = {txt, b64_char(g[17:12])};
      txt = {txt, (n > 1) ? b64_char(g[11:6]) : PadChar};
      txt = {txt, (n > 2) ? b64_char(g[5:0]) : PadChar};
      i += 3;
    end
    mangle = MangleNone;
    if ($urandom_range(0, 2) == 0) mangle = mangle_e'($urandom_range(0, 3));
    k = $urandom_range(0, txt.size() - 1);
    case (mangle)
      MangleByte:     txt[k] = 8'($urandom);
      MangleStrayPad: txt[k] = PadChar;
      MangleShort:    txt = txt[0:$-1];
      MangleLong:     txt = {txt, b64_char(6'($urandom))};
      default: ;
    endcase
    for (i = 0; i < txt.size(); i++) queue_req(txt[i], close && (i == txt.size() - 1));
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_syms.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_direction(input dir_e d);
    @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_direction_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pred_dir = d;
    clear_msg();
    @(negedge clk_i);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // encode on reset direction: one, two and three byte groups
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b0);
    queue_req(8'hFF, 1'b1);
    queue_req(8'h00, 1'b0);
    queue_req(8'hFF, 1'b0);
    queue_req(8'h80, 1'b1);
    wait_idle();

    write_direction(DirEncode);
    while (queued_reqs < 56) add_random_bytes($urandom_range(1, 7), 1'b1);
    add_random_bytes(2, 1'b0);  // left open, cleared by the write
    wait_idle();

    write_direction(DirDecode);
    add_text("Az09", 1'b1);
    add_text("/+==", 1'b1);     // nonzero pad bits
    add_text("=", 1'b1);
    add_text("AB=", 1'b1);
    add_text("AB=A", 1'b1);
    add_text("AB", 1'b0);
    queue_req(8'hFF, 1'b0);     // bad char, rest dropped
    queue_req(PadChar, 1'b1);
    add_text("ABC=A", 1'b1);    // pad in fourth slot, not last
    wait_idle();

    while (queued_reqs < 120) begin
      if ($urandom_range(0, 4) == 0) begin
        add_random_bytes($urandom_range(1, 6), 1'b1);
      end else begin
        add_decode_msg($urandom_range(1, 9), 1'b1);
      end
    end
    add_decode_msg(3, 1'b0);
    wait_idle();

    // receiver holds off while requests keep coming
    write_direction(DirEncode);
    no_idle = 1'b1;
    rx_hold = 400;
    while (queued_reqs < 150) add_random_bytes($urandom_range(1, 8), 1'b1);
    wait_idle();

    write_direction(DirDecode);
    while (queued_reqs < 170) add_decode_msg($urandom_range(1, 9), 1'b1);
    wait_idle();

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
